@@ design/iodr_pkg.sv @@
// Package for the IPv4 option delete and repack block.
// Holds transaction payload types, the sequencer state type and fixed constants.
// No dependencies.
package iodr_pkg;

  localparam int POS_W        = 7;
  localparam int HEADER_BYTES = 20;
  localparam int MAX_RESULTS  = 40;

  localparam logic [7:0] OPT_NOP = 8'd1;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_RUN  = 1'b1
  } iodr_op_t;

  typedef struct packed {
    iodr_op_t    opcode;
    logic [5:0]  byte_index;
    logic [7:0]  byte_value;
    logic [5:0]  options_length;
    logic [5:0]  security_offset;
    logic [5:0]  source_route_offset;
    logic [5:0]  record_route_offset;
    logic [5:0]  timestamp_offset;
    logic [5:0]  alert_offset;
  } iodr_in_t;

  typedef struct packed {
    logic [5:0]  out_index;
    logic [7:0]  out_byte;
    logic        last;
    logic        all_removed;
    logic [5:0]  new_length;
    logic [5:0]  header_delta;
    logic [5:0]  new_source_route;
    logic [5:0]  new_record_route;
    logic [5:0]  new_timestamp;
    logic [5:0]  new_alert;
  } iodr_out_t;

  typedef struct packed {
    logic             we;
    logic [POS_W-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [POS_W-1:0] raddr;
  } iodr_mem_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CUT_RD,
    S_CUT_LEN,
    S_SHIFT,
    S_MV_RD,
    S_MV_WR,
    S_WK_RD,
    S_WK_TYPE,
    S_WK_LEN,
    S_ROUND,
    S_EMIT_RD,
    S_EMIT,
    S_SINGLE
  } iodr_state_t;

endpackage

@@ design/iodr_store.sv @@
// Option byte store: one write port, one read port with registered data.
// Reads past the store answer zero. Depends on iodr_pkg.
module iodr_store
  import iodr_pkg::*;
#(
  parameter int OPTION_BYTES = 40
) (
  input  logic          clk,
  input  iodr_mem_req_t req,
  output logic [7:0]    rdata
);

  localparam int AW = $clog2(OPTION_BYTES);
  localparam logic [POS_W-1:0] DEPTH = POS_W'(OPTION_BYTES);

  logic [7:0] mem [OPTION_BYTES];
  logic [7:0] q_r;
  logic       oob_r;

  always_ff @(posedge clk) begin
    if (req.we && (req.waddr < DEPTH)) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      oob_r <= (req.raddr >= DEPTH);
      if (req.raddr < DEPTH) begin
        q_r <= mem[req.raddr[AW-1:0]];
      end
    end
  end

  assign rdata = oob_r ? 8'd0 : q_r;

endmodule

@@ design/ip_option_delete_repack.sv @@
// IPv4 option delete and repack, top level.
// Load transactions (opcode OP_LOAD) write one option byte into the store;
// a byte_index past the store is dropped. A run transaction
// (opcode OP_RUN) cuts the security option out of the stored bytes, walks the
// remaining options, rounds the end up to a multiple of four and emits one
// result per new option byte, with last on the final one. When no other
// option is present a single all_removed result is given instead; a new
// length of zero also gives a single result. in_ready is high only while
// the sequencer is idle; loads sustain one per cycle. A run sets up the cut,
// moves each remaining byte down with a read and a write, reads the type of
// each option in the walk and, unless it is a NOP, its length, rounds the
// end, then emits one byte per cycle while the receiver is ready; all of it
// paced by the single read port of the option store and its registered read.
// Each result is valid in the cycle after the sequencer produces it.
// Results sit in an output register: a stalled receiver holds the current
// result and the sequencer waits. Reset clears the sequencer and the output
// valid; the store is not cleared.
// Depends on iodr_pkg and iodr_store.
module ip_option_delete_repack
  import iodr_pkg::*;
#(
  parameter int OPTION_BYTES = 40
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  iodr_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output iodr_out_t out_data
);

  localparam logic [POS_W-1:0] OB_P   = POS_W'(OPTION_BYTES);
  localparam logic [POS_W-1:0] MAX_P  = POS_W'(MAX_RESULTS);
  localparam logic [5:0]       HDR_P  = 6'(HEADER_BYTES);

  function automatic logic [5:0] shift_down(logic [5:0] v, logic [5:0] sec,
                                            logic [POS_W-1:0] clen);
    logic [5:0] r;
    r = v;
    if (v > sec) begin
      r = (POS_W'(v) >= clen) ? 6'(POS_W'(v) - clen) : 6'd0;
    end
    return r;
  endfunction

  iodr_state_t      st_r, st_nxt;
  iodr_mem_req_t    mem_req;
  logic [7:0]       rdata;

  logic [POS_W-1:0] len_r, off_r, clen_r, j_r, iter_r, end_r, nlen_r, delta_r;
  logic [POS_W-1:0] n_r, idx_r;
  logic [5:0]       sec_r;
  logic [5:0]       offs_r [4];
  logic             sec_ok_r, all_r;

  logic             out_valid_r;
  iodr_out_t        out_data_r;
  logic             out_free, out_load;
  iodr_out_t        out_nxt;

  logic             run_acc, load_acc;
  logic [POS_W-1:0] len_sat, in_off;
  logic             in_all;
  logic [POS_W-1:0] rem, clen_clip, end_clip, nlen_c, step_nxt;
  logic [8:0]       step_sum;
  logic             step_bad, emit_last;

  iodr_store #(
    .OPTION_BYTES(OPTION_BYTES)
  ) u_store (
    .clk  (clk),
    .req  (mem_req),
    .rdata(rdata)
  );

  assign in_ready = (st_r == S_IDLE);
  assign run_acc  = in_valid && in_ready && (in_data.opcode == OP_RUN);
  assign load_acc = in_valid && in_ready && (in_data.opcode == OP_LOAD);

  assign len_sat = (POS_W'(in_data.options_length) > OB_P) ? OB_P
                                                              : POS_W'(in_data.options_length);
  assign in_off  = POS_W'(in_data.security_offset - HDR_P);
  assign in_all  = (in_data.source_route_offset | in_data.record_route_offset |
                    in_data.timestamp_offset | in_data.alert_offset) == 6'd0;

  assign rem       = len_r - off_r;
  assign clen_clip = ({1'b0, rdata} > 9'(rem)) ? rem : POS_W'(rdata);
  assign step_sum  = 9'(iter_r) + 9'(rdata);
  assign step_bad  = (rdata < 8'd2) || (step_sum > 9'(OPTION_BYTES));
  assign step_nxt  = step_bad ? POS_W'(iter_r + 1'b1) : POS_W'(step_sum);
  assign end_clip  = (end_r > len_r) ? len_r : end_r;
  assign nlen_c    = POS_W'(end_clip + POS_W'(3)) & ~POS_W'(3);
  assign emit_last = (POS_W'(idx_r + 1'b1) == n_r);

  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE:    if (run_acc) st_nxt = in_all ? S_SINGLE : S_CUT_RD;
      S_CUT_RD:  st_nxt = sec_ok_r ? S_CUT_LEN : S_SHIFT;
      S_CUT_LEN: st_nxt = S_SHIFT;
      S_SHIFT:   st_nxt = ((clen_r != '0) && (POS_W'(off_r + clen_r) < len_r)) ? S_MV_RD
                                                                             : S_WK_RD;
      S_MV_RD:   st_nxt = S_MV_WR;
      S_MV_WR:   st_nxt = (POS_W'(j_r + 1'b1 + clen_r) < len_r) ? S_MV_RD : S_WK_RD;
      S_WK_RD:   st_nxt = (iter_r >= len_r) ? S_ROUND : S_WK_TYPE;
      S_WK_TYPE: st_nxt = (rdata == OPT_NOP) ? S_WK_RD : S_WK_LEN;
      S_WK_LEN:  st_nxt = S_WK_RD;
      S_ROUND:   st_nxt = (nlen_c == '0) ? S_SINGLE : S_EMIT_RD;
      S_EMIT_RD: st_nxt = S_EMIT;
      S_EMIT:    if (out_free && emit_last) st_nxt = S_IDLE;
      S_SINGLE:  if (out_free) st_nxt = S_IDLE;
      default:   st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    mem_req       = '0;
    mem_req.waddr = POS_W'(in_data.byte_index);
    mem_req.wdata = in_data.byte_value;
    out_load      = 1'b0;
    out_nxt       = out_data_r;
    case (st_r)
      S_IDLE: begin
        mem_req.we = load_acc;
      end
      S_CUT_RD: begin
        mem_req.re    = sec_ok_r;
        mem_req.raddr = POS_W'(off_r + 1'b1);
      end
      S_MV_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = POS_W'(j_r + clen_r);
      end
      S_MV_WR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = j_r;
        mem_req.wdata = rdata;
      end
      S_WK_RD: begin
        mem_req.re    = (iter_r < len_r);
        mem_req.raddr = iter_r;
      end
      S_WK_TYPE: begin
        mem_req.re    = (rdata != OPT_NOP);
        mem_req.raddr = POS_W'(iter_r + 1'b1);
      end
      S_EMIT_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = idx_r;
      end
      S_EMIT: begin
        mem_req.re    = out_free && !emit_last;
        mem_req.raddr = POS_W'(idx_r + 1'b1);
        out_load      = out_free;
        out_nxt.out_index   = idx_r[5:0];
        out_nxt.out_byte    = rdata;
        out_nxt.last        = emit_last;
        out_nxt.all_removed = 1'b0;
        out_nxt.new_length  = nlen_r[5:0];
        out_nxt.header_delta = delta_r[5:0];
        out_nxt.new_source_route = offs_r[0];
        out_nxt.new_record_route = offs_r[1];
        out_nxt.new_timestamp    = offs_r[2];
        out_nxt.new_alert        = offs_r[3];
      end
      S_SINGLE: begin
        out_load            = out_free;
        out_nxt.out_index   = 6'd0;
        out_nxt.out_byte    = 8'd0;
        out_nxt.last        = 1'b1;
        out_nxt.all_removed = all_r;
        out_nxt.new_length  = 6'd0;
        out_nxt.header_delta = delta_r[5:0];
        out_nxt.new_source_route = offs_r[0];
        out_nxt.new_record_route = offs_r[1];
        out_nxt.new_timestamp    = offs_r[2];
        out_nxt.new_alert        = offs_r[3];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_load || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_nxt;
    end
    case (st_r)
      S_IDLE: begin
        if (run_acc) begin
          len_r     <= len_sat;
          sec_r     <= in_data.security_offset;
          off_r     <= in_off;
          sec_ok_r  <= (in_data.security_offset >= HDR_P) && (in_off < len_sat);
          all_r     <= in_all;
          offs_r[0] <= in_data.source_route_offset;
          offs_r[1] <= in_data.record_route_offset;
          offs_r[2] <= in_data.timestamp_offset;
          offs_r[3] <= in_data.alert_offset;
          delta_r   <= len_sat;
          clen_r    <= '0;
          iter_r    <= '0;
          end_r     <= '0;
        end
      end
      S_CUT_LEN: clen_r <= clen_clip;
      S_SHIFT: begin
        for (int k = 0; k < 4; k++) begin
          offs_r[k] <= shift_down(offs_r[k], sec_r, clen_r);
        end
        j_r <= off_r;
      end
      S_MV_WR: j_r <= POS_W'(j_r + 1'b1);
      S_WK_TYPE: begin
        if (rdata == OPT_NOP) begin
          iter_r <= POS_W'(iter_r + 1'b1);
        end
      end
      S_WK_LEN: begin
        iter_r <= step_nxt;
        end_r  <= step_nxt;
      end
      S_ROUND: begin
        nlen_r  <= nlen_c;
        delta_r <= (len_r > nlen_c) ? POS_W'(len_r - nlen_c) : '0;
        n_r     <= (nlen_c > MAX_P) ? MAX_P : nlen_c;
        idx_r   <= '0;
      end
      S_EMIT: begin
        if (out_free) begin
          idx_r <= POS_W'(idx_r + 1'b1);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_all_removed_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.all_removed |-> out_data.last && (out_data.new_length == 6'd0))
    else $error("all_removed result is not a single empty result");

  a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.opcode == OP_RUN) |=> !in_ready)
    else $error("input accepted while a run is in progress");

  a_no_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_WK_RD) || (st_r == S_WK_TYPE) || (st_r == S_WK_LEN) || (st_r == S_EMIT)
    |-> !mem_req.we)
    else $error("store written during walk or emission");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.opcode == OP_LOAD) |=> in_ready)
    else $error("load left the sequencer busy");

endmodule

@@ tb/ip_option_delete_repack_tb.sv @@
// Testbench for ip_option_delete_repack: loads option bytes, runs security-option
// deletions and checks every repacked byte against an in-bench prediction.
// Depends on iodr_pkg and the ip_option_delete_repack RTL.
module ip_option_delete_repack_tb
  import iodr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int OPTION_BYTES = 40;
  localparam int RAND_ITEMS   = 64;
  localparam int STALL_LIMIT  = 3000;
  localparam int TAIL_CYCLES  = 300;

  localparam logic [7:0] OPT_EOL  = 8'd0;
  localparam logic [7:0] OPT_RR   = 8'd7;
  localparam logic [7:0] OPT_TS   = 8'd68;
  localparam logic [7:0] OPT_SEC  = 8'd130;
  localparam logic [7:0] OPT_LSRR = 8'd131;
  localparam logic [7:0] OPT_SSRR = 8'd137;
  localparam logic [7:0] OPT_RA   = 8'd148;

  typedef enum int {
    K_SEC,
    K_SRR,
    K_RR,
    K_TS,
    K_RA,
    K_NOP
  } opt_kind_t;

  typedef struct {
    bit       drain;
    iodr_in_t item;
  } src_entry_t;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  iodr_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  iodr_out_t out_data;

  logic [7:0] opt_mem [OPTION_BYTES];
  src_entry_t option_tx_q [$];
  iodr_out_t  repacked_bytes [$];

  int       mismatches   = 0;
  int       queued_items = 0;
  int       quiet_cycles = 0;
  bit       in_fire      = 1'b0;
  bit       src_busy     = 1'b0;
  int       src_gap      = 0;
  int       src_burst    = 0;
  iodr_in_t tx_hold      = '0;
  int       sink_stall   = 0;
  int       sink_burst   = 0;

  ip_option_delete_repack #(
    .OPTION_BYTES(OPTION_BYTES)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [7:0] mem_at(int i);
    return (i < OPTION_BYTES) ? opt_mem[i] : 8'd0;
  endfunction

  function automatic void repack_options(iodr_in_t t);
    int        len, sec, cut, off, walk, stop, nlen, delta, n, step, i;
    int        offs [4];
    iodr_out_t r;
    if (t.opcode == OP_LOAD) begin
      if (int'(t.byte_index) < OPTION_BYTES) opt_mem[t.byte_index] = t.byte_value;
      return;
    end
    len = (int'(t.options_length) > OPTION_BYTES) ? OPTION_BYTES : int'(t.options_length);
    sec = t.security_offset;
    offs[0] = t.source_route_offset;
    offs[1] = t.record_route_offset;
    offs[2] = t.timestamp_offset;
    offs[3] = t.alert_offset;
    r = '0;
    if ((offs[0] | offs[1] | offs[2] | offs[3]) == 0) begin
      r.last         = 1'b1;
      r.all_removed  = 1'b1;
      r.header_delta = 6'(len);
      repacked_bytes.push_back(r);
      return;
    end
    cut = 0;
    if (sec >= HEADER_BYTES && sec - HEADER_BYTES < len) begin
      off = sec - HEADER_BYTES;
      cut = mem_at(off + 1);
      if (cut > len - off) cut = len - off;
      for (i = off; i < len - cut; i++) opt_mem[i] = opt_mem[i + cut];
    end
    for (i = 0; i < 4; i++) begin
      if (offs[i] > sec) offs[i] = (offs[i] >= cut) ? offs[i] - cut : 0;
    end
    walk = 0;
    stop = 0;
    while (walk < len) begin
      if (mem_at(walk) != OPT_NOP) begin
        step = mem_at(walk + 1);
        if (step < 2 || walk + step > OPTION_BYTES) step = 1;
        walk += step;
        stop = walk;
      end else begin
        walk++;
      end
    end
    if (stop > len) stop = len;
    nlen  = (stop + 3) & ~3;
    delta = (len > nlen) ? len - nlen : 0;
    r.new_length       = 6'(nlen);
    r.header_delta     = 6'(delta);
    r.new_source_route = 6'(offs[0]);
    r.new_record_route = 6'(offs[1]);
    r.new_timestamp    = 6'(offs[2]);
    r.new_alert        = 6'(offs[3]);
    if (nlen == 0) begin
      r.last = 1'b1;
      repacked_bytes.push_back(r);
      return;
    end
    n = (nlen > MAX_RESULTS) ? MAX_RESULTS : nlen;
    for (i = 0; i < n; i++) begin
      r.out_index = 6'(i);
      r.out_byte  = mem_at(i);
      r.last      = (i == n - 1);
      repacked_bytes.push_back(r);
    end
  endfunction

  function automatic void field_ok(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_result(iodr_out_t got);
    iodr_out_t want;
    if (repacked_bytes.size() == 0) begin
      $display("%t: unexpected result: expected none, actual %h", $time, got);
      mismatches++;
      return;
    end
    want = repacked_bytes.pop_front();
    field_ok("out_index", want.out_index, got.out_index);
    field_ok("out_byte", want.out_byte, got.out_byte);
    field_ok("last", want.last, got.last);
    field_ok("all_removed", want.all_removed, got.all_removed);
    field_ok("new_length", want.new_length, got.new_length);
    field_ok("header_delta", want.header_delta, got.header_delta);
    field_ok("new_source_route", want.new_source_route, got.new_source_route);
    field_ok("new_record_route", want.new_record_route, got.new_record_route);
    field_ok("new_timestamp", want.new_timestamp, got.new_timestamp);
    field_ok("new_alert", want.new_alert, got.new_alert);
  endfunction

  function automatic int pick_gap(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      burst = $urandom_range(10, 30);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic src_entry_t noise_entry(iodr_op_t op);
    src_entry_t  e;
    logic [63:0] bits;
    bits      = {$urandom(), $urandom()};
    e.drain   = 1'b0;
    e.item    = bits[$bits(iodr_in_t)-1:0];
    e.item.opcode = op;
    return e;
  endfunction

  function automatic void push_load(int idx, int val);
    src_entry_t e;
    e = noise_entry(OP_LOAD);
    e.item.byte_index = 6'(idx);
    e.item.byte_value = 8'(val);
    option_tx_q.push_back(e);
    queued_items++;
  endfunction

  function automatic void push_run(int len, int sec, int sr, int rr, int ts, int ra);
    src_entry_t e;
    e = noise_entry(OP_RUN);
    e.item.options_length      = 6'(len);
    e.item.security_offset     = 6'(sec);
    e.item.source_route_offset = 6'(sr);
    e.item.record_route_offset = 6'(rr);
    e.item.timestamp_offset    = 6'(ts);
    e.item.alert_offset        = 6'(ra);
    option_tx_q.push_back(e);
    queued_items++;
  endfunction

  function automatic void push_drain();
    src_entry_t e;
    e.drain = 1'b1;
    e.item  = '0;
    option_tx_q.push_back(e);
  endfunction

  function automatic int rand_off();
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 63);
  endfunction

  function automatic void push_packet();
    logic [7:0] pkt [OPTION_BYTES];
    int         where [5];
    int         budget, pos, olen, plen, len, sec, r, i;
    bit         sec_first;
    opt_kind_t  kind;
    logic [7:0] otype;
    for (i = 0; i < 5; i++) where[i] = -1;
    budget    = ($urandom_range(0, 3) == 0) ? OPTION_BYTES : $urandom_range(4, 16);
    sec_first = ($urandom_range(0, 1) != 0);
    pos       = 0;
    while (pos < budget) begin
      kind = (pos == 0 && sec_first) ? K_SEC : opt_kind_t'($urandom_range(0, 5));
      case (kind)
        K_SEC: begin
          otype = OPT_SEC;
          olen  = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 12) : 11;
        end
        K_SRR: begin
          otype = ($urandom_range(0, 1) != 0) ? OPT_LSRR : OPT_SSRR;
          olen  = 3 + 4 * $urandom_range(1, 2);
        end
        K_RR: begin
          otype = OPT_RR;
          olen  = 3 + 4 * $urandom_range(0, 2);
        end
        K_TS: begin
          otype = OPT_TS;
          olen  = 4 + 4 * $urandom_range(0, 2);
        end
        K_RA: begin
          otype = OPT_RA;
          olen  = 4;
        end
        default: begin
          otype = OPT_NOP;
          olen  = 1;
        end
      endcase
      if (pos + olen > budget) break;
      if (kind != K_NOP && where[kind] < 0) where[kind] = pos;
      pkt[pos] = otype;
      if (olen > 1) pkt[pos + 1] = 8'(olen);
      for (i = 2; i < olen; i++) pkt[pos + i] = 8'($urandom_range(0, 255));
      pos += olen;
    end
    r    = $urandom_range(0, 9);
    plen = (pos + 3) & ~3;
    if (r == 4 && plen + 4 <= OPTION_BYTES) plen += 4;
    for (i = pos; i < plen; i++) pkt[i] = OPT_EOL;
    if (r == 0 && plen > 0) pkt[$urandom_range(0, plen - 1)] = 8'($urandom_range(0, 255));
    for (i = 0; i < plen; i++) push_load(i, pkt[i]);
    len = (r == 1) ? $urandom_range(0, OPTION_BYTES) : plen;
    sec = (where[K_SEC] >= 0) ? HEADER_BYTES + where[K_SEC] : $urandom_range(0, 63);
    if (r == 2) sec = $urandom_range(0, 63);
    for (i = K_SRR; i <= K_RA; i++) begin
      where[i] = (where[i] >= 0 && r != 3) ? HEADER_BYTES + where[i] : 0;
    end
    push_run(len, sec, where[K_SRR], where[K_RR], where[K_TS], where[K_RA]);
  endfunction

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_fire) begin
        src_busy = 1'b0;
        in_fire  = 1'b0;
      end
      if (!src_busy) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (option_tx_q.size() > 0) begin
          if (option_tx_q[0].drain) begin
            if (repacked_bytes.size() == 0) option_tx_q.delete(0);
          end else begin
            tx_hold  = option_tx_q[0].item;
            option_tx_q.delete(0);
            src_busy = 1'b1;
            src_gap  = pick_gap(src_burst);
          end
        end
      end
    end
    in_valid <= src_busy;
    in_data  <= tx_hold;
  end

  always @(negedge clk) begin
    if (sink_stall > 0) begin
      sink_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      sink_stall = pick_gap(sink_burst);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        repack_options(in_data);
        in_fire = 1'b1;
      end
      if (out_valid && out_ready) check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  initial begin
    int k, r, n;
    for (k = 0; k < OPTION_BYTES; k++) push_load(k, OPT_NOP);

    // loads past the store are dropped
    push_load(40, 8'hFF);
    push_load(63, 8'h00);
    // nothing else present: whole area dropped
    push_run(40, 20, 0, 0, 0, 0);
    // empty area with other options present
    push_run(0, 20, 0, 24, 0, 0);
    // security in front, record route and router alert behind; length saturates
    push_load(0, OPT_SEC);
    push_load(1, 11);
    push_load(11, OPT_RR);
    push_load(12, 7);
    push_load(18, OPT_RA);
    push_load(19, 4);
    push_run(63, 20, 25, 31, 0, 38);
    // oversized cut length is clipped; walk repair on short and long length bytes
    push_load(0, OPT_SEC);
    push_load(1, 200);
    push_run(8, 20, 0, 22, 0, 0);
    // offsets inside the cut saturate at zero
    push_load(1, 30);
    push_run(40, 20, 63, 21, 59, 0);
    // security offset inside the fixed header, then past the option area
    push_run(16, 5, 40, 0, 0, 3);
    push_run(12, 32, 0, 0, 45, 0);
    // rounding grows past the old length
    push_load(0, OPT_TS);
    push_load(1, 5);
    push_run(5, 45, 0, 0, 20, 0);
    push_drain();

    n = queued_items;
    while (queued_items - n < RAND_ITEMS) begin
      r = $urandom_range(0, 9);
      if (r < 6) begin
        push_packet();
      end else if (r < 8) begin
        push_run($urandom_range(0, 63), $urandom_range(0, 63), rand_off(), rand_off(),
                 rand_off(), rand_off());
      end else if (r == 8) begin
        for (k = $urandom_range(1, 3); k > 0; k--)
          push_load($urandom_range(0, 63), $urandom_range(0, 255));
      end else begin
        push_drain();
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while ((option_tx_q.size() != 0 || src_busy || repacked_bytes.size() != 0) &&
           quiet_cycles < STALL_LIMIT)
      @(negedge clk);

    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%t: no transaction for %0d cycles, %0d results outstanding", $time,
               STALL_LIMIT, repacked_bytes.size());
      $display("Verification failed");
    end else begin
      repeat (TAIL_CYCLES) @(posedge clk);
      if (mismatches == 0) begin
        $display("Verification passed");
      end else begin
        $display("Verification failed");
      end
    end
    $finish;
  end

endmodule
